>>> design/clcs_pkg.sv
// Shared types and display command codes for the character LCD cursor sequencer.
package clcs_pkg;

  localparam int unsigned CUR_W = 6;
  localparam int unsigned MAX_RESULTS = 57;
  localparam int unsigned RES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] SHIFT_RIGHT    = 8'h14;
  localparam logic [7:0] SHIFT_LEFT     = 8'h10;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_FUNCSET    = 8'h28;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;

  localparam logic [1:0] INIT_LAST = 2'd3;
  localparam logic [7:0] INIT_SEQ [4] = '{CMD_HOME, CMD_FUNCSET, CMD_CLEAR, CMD_DISPLAY_ON};

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_INIT  = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic             rs;
    logic [7:0]       bus_byte;
    logic [CUR_W-1:0] cursor_after;
    logic             last;
  } res_t;

  // Job handed from the front to the back; same shape as a request.
  typedef req_t job_t;

endpackage

>>> design/clcs_front.sv
// Front end: accepts requests, drops out-of-range cursor targets, queues jobs.
module clcs_front #(
  parameter int unsigned POSITIONS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  clcs_pkg::req_t in_req_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output clcs_pkg::job_t job_o
);
  import clcs_pkg::*;

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       keep, push, pop;

  // A set-cursor request past the last cell produces nothing; drop it here.
  assign keep = !((in_req_i.op == OP_SET) && ({1'b0, in_req_i.value} >= 9'(POSITIONS)));

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o && keep;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= in_req_i;
  end

endmodule

>>> design/clcs_back.sv
// Back end: owns the cursor and sequences each job into display byte writes.
module clcs_back #(
  parameter int unsigned LINE_LENGTH = 16,
  parameter int unsigned GAP_SHIFTS  = 24,
  parameter int unsigned POSITIONS   = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  clcs_pkg::job_t job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output clcs_pkg::res_t out_res_o
);
  import clcs_pkg::*;

  localparam int unsigned GW = (GAP_SHIFTS > 0) ? $clog2(GAP_SHIFTS + 1) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GAP  = 6'b000010,
    S_WALK = 6'b000100,
    S_DATA = 6'b001000,
    S_CLR  = 6'b010000,
    S_INIT = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CUR_W-1:0] cur_q, cur_d, tgt_q, tgt_d;
  logic [7:0]       char_q, char_d;
  logic             up_q, up_d, pend_q, pend_d;
  logic [GW-1:0]    gap_cnt_q, gap_cnt_d, gap_inc;
  logic [1:0]       init_idx_q, init_idx_d;
  logic [RES_W-1:0] res_cnt_q, res_cnt_d;
  logic             out_valid_q;
  res_t             out_res_q, res_n;

  logic             adv, emit, keep, run_end, at_line, at_end, gap_now;
  logic [CUR_W-1:0] cur_step, cur_out;
  logic [7:0]       byte_n;
  logic             rs_n;

  assign adv      = !out_valid_q || out_ready_i;
  assign keep     = (res_cnt_q < RES_W'(MAX_RESULTS));
  assign at_line  = (cur_q == CUR_W'(LINE_LENGTH));
  assign at_end   = ({1'b0, cur_q} == (CUR_W + 1)'(POSITIONS));
  assign gap_inc  = gap_cnt_q + GW'(1);
  assign gap_now  = at_line && (gap_cnt_q != GW'(GAP_SHIFTS));
  assign cur_step = up_q ? cur_q + CUR_W'(1) : cur_q - CUR_W'(1);

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    tgt_d      = tgt_q;
    char_d     = char_q;
    up_d       = up_q;
    pend_d     = pend_q;
    gap_cnt_d  = gap_cnt_q;
    init_idx_d = init_idx_q;
    res_cnt_d  = res_cnt_q;
    emit       = 1'b0;
    run_end    = 1'b0;
    rs_n       = 1'b0;
    byte_n     = 8'h00;
    cur_out    = cur_q;
    job_ready_o = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          char_d     = job_i.value;
          res_cnt_d  = '0;
          gap_cnt_d  = '0;
          init_idx_d = 2'd0;
          pend_d     = 1'b0;
          case (job_i.op)
            OP_WRITE: begin
              pend_d = 1'b1;
              if (at_line) begin
                state_d = (GAP_SHIFTS != 0) ? S_GAP : S_DATA;
              end else if (at_end) begin
                // walk home first, then write
                tgt_d   = '0;
                up_d    = 1'b0;
                state_d = S_WALK;
              end else begin
                state_d = S_DATA;
              end
            end
            OP_SET: begin
              tgt_d = job_i.value[CUR_W-1:0];
              up_d  = (job_i.value[CUR_W-1:0] > cur_q);
              if (job_i.value[CUR_W-1:0] != cur_q) state_d = S_WALK;
            end
            OP_CLEAR: begin
              cur_d   = '0;
              state_d = S_CLR;
            end
            OP_INIT: begin
              cur_d   = '0;
              state_d = S_INIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_GAP: begin
        if (adv) begin
          emit      = 1'b1;
          byte_n    = SHIFT_RIGHT;
          gap_cnt_d = gap_inc;
          if (gap_inc == GW'(GAP_SHIFTS)) state_d = S_DATA;
        end
      end
      S_WALK: begin
        if (adv) begin
          emit   = 1'b1;
          byte_n = up_q ? SHIFT_RIGHT : SHIFT_LEFT;
          if (gap_now) begin
            // bridge the hole between the lines; cursor holds
            gap_cnt_d = gap_inc;
          end else begin
            cur_d     = cur_step;
            cur_out   = cur_step;
            gap_cnt_d = '0;
            if (cur_step == tgt_q) begin
              run_end = !pend_q;
              state_d = pend_q ? S_DATA : S_IDLE;
            end
          end
        end
      end
      S_DATA: begin
        if (adv) begin
          emit    = 1'b1;
          rs_n    = 1'b1;
          byte_n  = char_q;
          cur_d   = cur_q + CUR_W'(1);
          cur_out = cur_q + CUR_W'(1);
          run_end = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        if (adv) begin
          emit    = 1'b1;
          byte_n  = CMD_CLEAR;
          run_end = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_INIT: begin
        if (adv) begin
          emit       = 1'b1;
          byte_n     = INIT_SEQ[init_idx_q];
          init_idx_d = init_idx_q + 2'd1;
          if (init_idx_q == INIT_LAST) begin
            run_end = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Drop writes past the result limit but keep stepping the cursor.
    if (emit && keep) res_cnt_d = res_cnt_q + RES_W'(1);

    res_n.rs           = rs_n;
    res_n.bus_byte     = byte_n;
    res_n.cursor_after = cur_out;
    res_n.last         = run_end || (res_cnt_q == RES_W'(MAX_RESULTS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      res_cnt_q   <= '0;
      gap_cnt_q   <= '0;
      init_idx_q  <= 2'd0;
      pend_q      <= 1'b0;
      up_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      res_cnt_q  <= res_cnt_d;
      gap_cnt_q  <= gap_cnt_d;
      init_idx_q <= init_idx_d;
      pend_q     <= pend_d;
      up_q       <= up_d;
      if (adv) out_valid_q <= emit && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q  <= tgt_d;
    char_q <= char_d;
    if (adv) out_res_q <= res_n;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

>>> design/char_lcd_cursor_sequencer.sv
// Top level of the character LCD cursor sequencer.
//
//   channel | direction | handshake                | payload
//   request | in        | in_valid_i / in_ready_o  | in_req_i  (op, value)
//   write   | out       | out_valid_o / out_ready_i| out_res_o (rs, bus_byte, cursor_after, last)
//
// Each request is first loaded into the sequencer while it is idle, then it
// yields one byte write per cycle unless the output stalls: a character write
// at an ordinary cell gives one data byte, a cursor walk a shift per step and per gap shift.
// A two-entry queue lets requests arrive while the sequencer is busy.
// Reset puts the cursor at cell 0 and empties the queue and output register.
// A stalled output holds the sequencer; a full queue deasserts in_ready_o.
module char_lcd_cursor_sequencer #(
  parameter int unsigned LINE_LENGTH = 16,
  parameter int unsigned GAP_SHIFTS  = 24,
  parameter int unsigned POSITIONS   = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  clcs_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output clcs_pkg::res_t out_res_o
);
  import clcs_pkg::*;

  logic job_valid, job_ready;
  job_t job;

  clcs_front #(
    .POSITIONS (POSITIONS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  clcs_back #(
    .LINE_LENGTH (LINE_LENGTH),
    .GAP_SHIFTS  (GAP_SHIFTS),
    .POSITIONS   (POSITIONS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  // A data byte always closes its request's run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.rs |-> out_res_o.last)
    else $error("data byte not marked last");

  // Clear and init leave the cursor at home.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.rs && (out_res_o.bus_byte == CMD_CLEAR)
      |-> (out_res_o.cursor_after == '0))
    else $error("clear command with cursor away from home");

  // Hold a stalled write unchanged until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("write changed while stalled");

endmodule
